### rtl/s2d_pkg.sv
// Shared types and constants for the sparse-to-dense scatter address block.
// Used by every module under rtl/; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package s2d_pkg;

    localparam int ADDR_W       = 48;
    localparam int COORD_W      = 16;
    localparam int SIZE_W       = 12;
    localparam int VALUE_W      = 32;
    localparam int DIMS_W       = 3;
    localparam int NUM_COORDS   = 4;
    localparam int STEP_W       = 2;
    // Largest stride is the product of three sizes; a stride that feeds the
    // stride multiplier is the product of at most two.
    localparam int STRIDE_W     = 3 * SIZE_W;
    localparam int STRIDE_MUL_W = 2 * SIZE_W;
    localparam int CFG_IDX_W    = 3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DIMS  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE0 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE1 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE2 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE3 = 3'd4;

    typedef logic [SIZE_W-1:0]   t_size;
    typedef logic [STRIDE_W-1:0] t_stride;
    typedef logic [ADDR_W-1:0]   t_addr;

    typedef struct packed {
        logic                      start_req;
        logic signed [COORD_W-1:0] coord0;
        logic signed [COORD_W-1:0] coord1;
        logic signed [COORD_W-1:0] coord2;
        logic signed [COORD_W-1:0] coord3;
        logic [VALUE_W-1:0]        entry_value;
    } t_in_item;

    typedef struct packed {
        logic               write_enable;
        logic [ADDR_W-1:0]  write_address;
        logic [VALUE_W-1:0] write_value;
        logic               failed;
    } t_out_item;

    // What one lane hands to the merge stage
    typedef struct packed {
        logic              in_range;
        logic [ADDR_W-1:0] term;
    } t_lane_res;

endpackage

`default_nettype wire

### rtl/s2d_shape.sv
// Shape registers (dimension count, sizes) and the row-major stride table.
// Strides are rebuilt by a four-step sequencer sharing one multiplier.
// Depends on s2d_pkg.
`timescale 1ns / 1ps
`default_nettype none

module s2d_shape #(
    parameter int LANES = 4
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_wr,
    input  wire logic [s2d_pkg::CFG_IDX_W-1:0]   i_wr_index,
    input  wire logic [s2d_pkg::SIZE_W-1:0]      i_wr_data,
    output logic [s2d_pkg::DIMS_W-1:0]           o_used_dims,
    output s2d_pkg::t_size                       o_size   [s2d_pkg::NUM_COORDS],
    output s2d_pkg::t_stride                     o_stride [s2d_pkg::NUM_COORDS],
    output logic                                 o_busy
);

    logic [s2d_pkg::DIMS_W-1:0] r_dims;
    s2d_pkg::t_size             r_size   [s2d_pkg::NUM_COORDS];
    s2d_pkg::t_stride           r_stride [s2d_pkg::NUM_COORDS];
    logic                       r_busy;
    logic [s2d_pkg::STEP_W-1:0] r_step;

    logic [s2d_pkg::DIMS_W-1:0] used_dims;
    logic [s2d_pkg::STEP_W-1:0] step_up;
    logic [s2d_pkg::DIMS_W-1:0] step_ext;
    s2d_pkg::t_stride           n_stride_val;

    assign used_dims = (r_dims > s2d_pkg::DIMS_W'(LANES)) ? s2d_pkg::DIMS_W'(LANES) : r_dims;
    assign step_up   = r_step + 1'b1;
    assign step_ext  = s2d_pkg::DIMS_W'(r_step);

    always_comb begin
        if (step_ext >= used_dims) begin
            n_stride_val = '0;
        end else if (step_ext + 1'b1 == used_dims) begin
            n_stride_val = s2d_pkg::STRIDE_W'(1);
        end else begin
            n_stride_val = s2d_pkg::STRIDE_W'(
                r_stride[step_up][s2d_pkg::STRIDE_MUL_W-1:0] * r_size[step_up]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dims <= s2d_pkg::DIMS_W'(1);
            for (int i = 0; i < s2d_pkg::NUM_COORDS; i++) begin
                r_size[i]   <= s2d_pkg::SIZE_W'(1);
                r_stride[i] <= (i == 0) ? s2d_pkg::STRIDE_W'(1) : '0;
            end
            r_busy <= 1'b0;
            r_step <= '0;
        end else begin
            if (r_busy) begin
                r_stride[r_step] <= n_stride_val;
            end
            if (i_wr) begin
                unique case (i_wr_index)
                    s2d_pkg::CFG_DIMS:  r_dims    <= i_wr_data[s2d_pkg::DIMS_W-1:0];
                    s2d_pkg::CFG_SIZE0: r_size[0] <= i_wr_data;
                    s2d_pkg::CFG_SIZE1: r_size[1] <= i_wr_data;
                    s2d_pkg::CFG_SIZE2: r_size[2] <= i_wr_data;
                    s2d_pkg::CFG_SIZE3: r_size[3] <= i_wr_data;
                    default: ;
                endcase
            end
            // restart the rebuild from the innermost entry
            if (i_wr && (i_wr_index <= s2d_pkg::CFG_SIZE3)) begin
                r_busy <= 1'b1;
                r_step <= s2d_pkg::STEP_W'(s2d_pkg::NUM_COORDS - 1);
            end else if (r_busy) begin
                if (r_step == '0) begin
                    r_busy <= 1'b0;
                end else begin
                    r_step <= r_step - 1'b1;
                end
            end
        end
    end

    assign o_used_dims = used_dims;
    assign o_size      = r_size;
    assign o_stride    = r_stride;
    assign o_busy      = r_busy;

endmodule

`default_nettype wire

### rtl/s2d_lane.sv
// One coordinate lane: bounds check and stride product, registered.
// Depends on s2d_pkg.
`timescale 1ns / 1ps
`default_nettype none

module s2d_lane (
    input  wire logic                              i_clk,
    input  wire logic                              i_en,
    input  wire logic                              i_used,
    input  wire logic signed [s2d_pkg::COORD_W-1:0] i_coord,
    input  wire s2d_pkg::t_size                    i_size,
    input  wire s2d_pkg::t_stride                  i_stride,
    output s2d_pkg::t_lane_res                     o_res
);

    s2d_pkg::t_lane_res r_res;
    s2d_pkg::t_lane_res n_res;
    logic               in_bounds;

    // Unsigned compare: a negative coordinate never passes
    assign in_bounds = !i_coord[s2d_pkg::COORD_W-1] &&
        (i_coord[s2d_pkg::COORD_W-2:0] < (s2d_pkg::COORD_W-1)'(i_size));

    always_comb begin
        n_res.in_range = !i_used || in_bounds;
        // Only in-range coordinates reach the address, so the low size bits suffice
        n_res.term = i_used
            ? s2d_pkg::ADDR_W'(i_stride * i_coord[s2d_pkg::SIZE_W-1:0])
            : '0;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_res <= n_res;
        end
    end

    assign o_res = r_res;

endmodule

`default_nettype wire

### rtl/s2d_merge.sv
// Merge stage: sums lane terms, keeps the sticky error and holds the result.
// Depends on s2d_pkg.
`timescale 1ns / 1ps
`default_nettype none

module s2d_merge #(
    parameter int LANES = 4,
    parameter int VW    = 32
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    input  wire logic                i_load,
    input  wire logic                i_start,
    input  wire logic [VW-1:0]       i_value,
    input  wire s2d_pkg::t_lane_res  i_lane [LANES],
    output logic                     o_valid,
    output s2d_pkg::t_out_item       o_item
);

    logic                r_valid;
    logic                r_err;
    s2d_pkg::t_out_item  r_item;
    logic                n_err;
    logic                any_bad;
    s2d_pkg::t_addr      sum;

    always_comb begin
        any_bad = 1'b0;
        sum     = '0;
        for (int i = 0; i < LANES; i++) begin
            any_bad = any_bad | !i_lane[i].in_range;
            sum     = sum + i_lane[i].term;
        end
        n_err = (i_start ? 1'b0 : r_err) | any_bad;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_err   <= 1'b0;
        end else if (i_load) begin
            r_valid <= i_valid;
            if (i_valid) begin
                r_err <= n_err;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && i_valid) begin
            r_item.write_enable  <= !n_err;
            r_item.write_address <= n_err ? '0 : sum;
            r_item.write_value   <= n_err ? '0 : s2d_pkg::VALUE_W'(i_value);
            r_item.failed        <= n_err;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

`default_nettype wire

### rtl/sparse_to_dense_scatter_address.sv
// Sparse-to-dense scatter address generator.
// Input channel takes one COO entry per transaction (start flag, four signed
// coordinates, value); output channel gives one dense write per entry.
// Configuration is written through a valid/ready port: index 0 is the number
// of dimensions, indexes 1..4 the sizes, outermost first.
// An accepted entry passes the lane register, then the merge/output register.
// Throughput: one entry per cycle while no stride rebuild or receiver stall
// holds the input, set by the per-coordinate lanes each holding one stride
// multiplier. Each write to a mapped register rebuilds the stride table,
// innermost entry first, on one shared multiplier; o_in_stall is high meanwhile.
// Reset (synchronous, active low) gives one dimension of size one, strides
// {1,0,0,0}, a clear error flag and an empty pipeline.
// When the receiver raises i_out_stall the result holds; the input keeps
// taking entries until the lane stage is full as well, then stalls.
// An out-of-range coordinate sets a sticky error that blocks writes until an
// entry with start_req set. Depends on s2d_pkg, s2d_shape, s2d_lane, s2d_merge.
`timescale 1ns / 1ps
`default_nettype none

module sparse_to_dense_scatter_address #(
    parameter int MAX_DIMS    = 4,
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire s2d_pkg::t_in_item             i_in_item,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output s2d_pkg::t_out_item                 o_out_item,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [s2d_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [s2d_pkg::SIZE_W-1:0]    i_cfg_data
);

    localparam int LANES = (MAX_DIMS < s2d_pkg::NUM_COORDS) ? MAX_DIMS : s2d_pkg::NUM_COORDS;
    localparam int VW    = (VALUE_WIDTH < s2d_pkg::VALUE_W) ? VALUE_WIDTH : s2d_pkg::VALUE_W;

    logic [s2d_pkg::DIMS_W-1:0] used_dims;
    s2d_pkg::t_size             size   [s2d_pkg::NUM_COORDS];
    s2d_pkg::t_stride           stride [s2d_pkg::NUM_COORDS];
    logic                       shape_busy;

    logic                       r_s1_valid;
    logic                       r_s1_start;
    logic [VW-1:0]              r_s1_value;

    logic                       adv_out;
    logic                       adv_s1;
    logic                       in_take;
    logic signed [s2d_pkg::COORD_W-1:0] coord [s2d_pkg::NUM_COORDS];
    s2d_pkg::t_lane_res         lane_res [LANES];

    assign o_cfg_ready = 1'b1;

    s2d_shape #(
        .LANES (LANES)
    ) u_shape (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_wr        (i_cfg_valid),
        .i_wr_index  (i_cfg_index),
        .i_wr_data   (i_cfg_data),
        .o_used_dims (used_dims),
        .o_size      (size),
        .o_stride    (stride),
        .o_busy      (shape_busy)
    );

    assign adv_out    = !o_out_valid || !i_out_stall;
    assign adv_s1     = !r_s1_valid || adv_out;
    assign o_in_stall = shape_busy || !adv_s1;
    assign in_take    = i_in_valid && !o_in_stall;

    assign coord[0] = i_in_item.coord0;
    assign coord[1] = i_in_item.coord1;
    assign coord[2] = i_in_item.coord2;
    assign coord[3] = i_in_item.coord3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (adv_s1) begin
            r_s1_valid <= in_take;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_start <= i_in_item.start_req;
            r_s1_value <= i_in_item.entry_value[VW-1:0];
        end
    end

    for (genvar g = 0; g < LANES; g++) begin : g_lane
        s2d_lane u_lane (
            .i_clk    (i_clk),
            .i_en     (in_take),
            .i_used   (s2d_pkg::DIMS_W'(g) < used_dims),
            .i_coord  (coord[g]),
            .i_size   (size[g]),
            .i_stride (stride[g]),
            .o_res    (lane_res[g])
        );
    end

    s2d_merge #(
        .LANES (LANES),
        .VW    (VW)
    ) u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s1_valid),
        .i_load  (adv_out),
        .i_start (r_s1_start),
        .i_value (r_s1_value),
        .i_lane  (lane_res),
        .o_valid (o_out_valid),
        .o_item  (o_out_item)
    );

endmodule

`default_nettype wire

### dv/s2d_scatter_checker.sv
// Checker for the sparse-to-dense scatter address block: watches the entry,
// result and configuration channels, predicts each dense write and compares.
// Depends on s2d_pkg for the item types and register indexes.
`timescale 1ns / 1ps

module s2d_scatter_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_stall,
    input  s2d_pkg::t_in_item             i_in_item,
    input  logic                          i_out_valid,
    input  logic                          i_out_stall,
    input  s2d_pkg::t_out_item            i_out_item,
    input  logic                          i_cfg_valid,
    input  logic                          i_cfg_ready,
    input  logic [s2d_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [s2d_pkg::SIZE_W-1:0]    i_cfg_data,
    output int                            o_fail_count,
    output int                            o_pending
);
    import s2d_pkg::*;

    logic [DIMS_W-1:0] shape_dims;
    t_size             shape_size [NUM_COORDS];
    logic              conv_failed;
    t_out_item         write_q [$];
    int                fails = 0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    // Work out the dense write for one entry; updates the sticky error.
    function automatic t_out_item predict_write(input t_in_item it);
        logic [ADDR_W-1:0]  stride [NUM_COORDS];
        logic [COORD_W-1:0] crd [NUM_COORDS];
        logic [ADDR_W-1:0]  addr;
        logic               bad;
        int                 n;
        t_out_item          res;
        n = (shape_dims > NUM_COORDS) ? NUM_COORDS : int'(shape_dims);
        crd[0] = it.coord0;
        crd[1] = it.coord1;
        crd[2] = it.coord2;
        crd[3] = it.coord3;
        for (int i = 0; i < NUM_COORDS; i++) stride[i] = '0;
        if (n > 0) begin
            stride[n-1] = ADDR_W'(1);
            for (int i = n - 1; i > 0; i--) stride[i-1] = stride[i] * shape_size[i];
        end
        if (it.start_req) conv_failed = 1'b0;
        addr = '0;
        bad  = 1'b0;
        for (int d = 0; d < n; d++) begin
            // negative coordinates compare as huge unsigned values
            if (crd[d][COORD_W-1] || (crd[d] >= {4'b0, shape_size[d]})) bad = 1'b1;
            addr = addr + stride[d] * {{(ADDR_W-COORD_W){crd[d][COORD_W-1]}}, crd[d]};
        end
        if (bad) conv_failed = 1'b1;
        res = '0;
        if (!conv_failed) begin
            res.write_enable  = 1'b1;
            res.write_address = addr;
            res.write_value   = it.entry_value;
        end
        res.failed = conv_failed;
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            shape_dims  = 3'd1;
            for (int d = 0; d < NUM_COORDS; d++) shape_size[d] = 12'd1;
            conv_failed = 1'b0;
            write_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_DIMS:  shape_dims    = i_cfg_data[DIMS_W-1:0];
                    CFG_SIZE0: shape_size[0] = i_cfg_data;
                    CFG_SIZE1: shape_size[1] = i_cfg_data;
                    CFG_SIZE2: shape_size[2] = i_cfg_data;
                    CFG_SIZE3: shape_size[3] = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) write_q.push_back(predict_write(i_in_item));
            if (i_out_valid && !i_out_stall) begin
                if (write_q.size() == 0) begin
                    $error("result transaction with no entry pending: %p", i_out_item);
                    fails++;
                end else begin
                    want = write_q.pop_front();
                    if (i_out_item.write_enable !== want.write_enable) begin
                        $error("write_enable expected %0b got %0b",
                               want.write_enable, i_out_item.write_enable);
                        fails++;
                    end
                    if (i_out_item.write_address !== want.write_address) begin
                        $error("write_address expected %h got %h",
                               want.write_address, i_out_item.write_address);
                        fails++;
                    end
                    if (i_out_item.write_value !== want.write_value) begin
                        $error("write_value expected %h got %h",
                               want.write_value, i_out_item.write_value);
                        fails++;
                    end
                    if (i_out_item.failed !== want.failed) begin
                        $error("failed expected %0b got %0b", want.failed, i_out_item.failed);
                        fails++;
                    end
                end
            end
        end
        o_fail_count <= fails;
        o_pending    <= write_q.size();
    end

endmodule

### dv/tb_sparse_to_dense_scatter_address.sv
// Top of the testbench for the sparse-to-dense scatter address block: clock,
// reset, shape configuration, directed and random entries, and the verdict.
// Depends on s2d_pkg, the block under test and s2d_scatter_checker.
`timescale 1ns / 1ps

module tb_sparse_to_dense_scatter_address;
    import s2d_pkg::*;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    t_in_item             i_in_item   = '0;
    logic                 i_out_stall = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [SIZE_W-1:0]    i_cfg_data  = '0;
    logic                 o_in_stall;
    logic                 o_out_valid;
    logic                 o_cfg_ready;
    t_out_item            o_out_item;

    int                fail_count;
    int                pending_writes;
    bit                calm = 1'b0;
    logic [DIMS_W-1:0] cur_dims = 3'd1;
    t_size             cur_size [NUM_COORDS];

    sparse_to_dense_scatter_address i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    s2d_scatter_checker u_scatter_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_in_item    (i_in_item),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_out_item   (o_out_item),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending_writes)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

    // Receiver back-pressure; none during a calm stretch.
    always @(posedge i_clk) begin
        if (calm) begin
            i_out_stall <= 1'b0;
        end else begin
            i_out_stall <= ($urandom_range(99) < 20);
        end
    end

    // Hold the entry until a transaction takes it; returns on the accepting edge.
    task automatic send_entry(input t_in_item it);
        if (!calm) begin
            while ($urandom_range(99) < 20) begin
                i_in_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    task automatic send_fields(input logic start, input logic [15:0] c0, input logic [15:0] c1,
                               input logic [15:0] c2, input logic [15:0] c3,
                               input logic [31:0] val);
        t_in_item it;
        it.start_req   = start;
        it.coord0      = c0;
        it.coord1      = c1;
        it.coord2      = c2;
        it.coord3      = c3;
        it.entry_value = val;
        send_entry(it);
    endtask

    task automatic stop_sender();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Wait until every predicted write has come out, then let the pipe settle.
    task automatic wait_drained();
        @(posedge i_clk);
        while (pending_writes != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SIZE_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_shape(input logic [SIZE_W-1:0] dims_word, input t_size s0,
                             input t_size s1, input t_size s2, input t_size s3);
        wait_drained();
        write_reg(CFG_DIMS, dims_word);
        write_reg(CFG_SIZE0, s0);
        write_reg(CFG_SIZE1, s1);
        write_reg(CFG_SIZE2, s2);
        write_reg(CFG_SIZE3, s3);
        cur_dims    = dims_word[DIMS_W-1:0];
        cur_size[0] = s0;
        cur_size[1] = s1;
        cur_size[2] = s2;
        cur_size[3] = s3;
    endtask

    // Mostly in-range entries for the current shape, with the odd broken coordinate.
    function automatic t_in_item make_entry();
        t_in_item           it;
        logic [COORD_W-1:0] crd [NUM_COORDS];
        int                 n;
        int                 d;
        n = (cur_dims > NUM_COORDS) ? NUM_COORDS : int'(cur_dims);
        for (d = 0; d < NUM_COORDS; d++) begin
            if (d < n && cur_size[d] != 0) begin
                crd[d] = 16'($urandom_range(cur_size[d] - 1));
            end else begin
                crd[d] = 16'($urandom);
            end
        end
        if (n > 0 && $urandom_range(99) < 6) begin
            d = $urandom_range(n - 1);
            case ($urandom_range(3))
                0: crd[d] = {4'b0, cur_size[d]};
                1: crd[d] = {1'b1, 15'($urandom)};
                2: crd[d] = 16'($urandom);
                default: crd[d] = 16'h7FFF;
            endcase
        end
        it.start_req   = ($urandom_range(99) < 15);
        it.coord0      = crd[0];
        it.coord1      = crd[1];
        it.coord2      = crd[2];
        it.coord3      = crd[3];
        it.entry_value = $urandom;
        return it;
    endfunction

    initial begin
        int                ph;
        int                k;
        logic [DIMS_W-1:0] dims;
        t_size             sz [NUM_COORDS];
        for (k = 0; k < NUM_COORDS; k++) cur_size[k] = 12'd1;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset shape: one dimension of size one
        send_fields(1'b0, 16'h0000, 16'($urandom), 16'($urandom), 16'($urandom),
                    32'hFFFF_FFFF);
        send_fields(1'b0, 16'h0001, 16'h0000, 16'h0000, 16'h0000, $urandom);
        send_fields(1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, $urandom);
        send_fields(1'b1, 16'h0000, 16'h0000, 16'h0000, 16'h0000, $urandom);
        send_fields(1'b0, 16'h8000, 16'h0000, 16'h0000, 16'h0000, $urandom);
        send_fields(1'b1, 16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'h0000_0000);
        stop_sender();

        set_shape(12'd4, 12'd3, 12'd5, 12'd7, 12'd9);
        send_fields(1'b1, 16'd0, 16'd0, 16'd0, 16'd0, 32'h0000_0000);
        send_fields(1'b0, 16'd2, 16'd4, 16'd6, 16'd8, 32'hFFFF_FFFF);
        send_fields(1'b0, 16'd2, 16'd4, 16'd6, 16'd9, $urandom);
        send_fields(1'b1, 16'd3, 16'd0, 16'd0, 16'd0, $urandom);
        send_fields(1'b1, 16'd0, 16'd5, 16'd0, 16'd0, $urandom);
        send_fields(1'b1, 16'd0, 16'd0, 16'd7, 16'd0, $urandom);
        send_fields(1'b1, 16'd0, 16'd0, 16'd0, 16'hFFFF, $urandom);
        send_fields(1'b1, 16'd1, 16'd2, 16'd3, 16'd4, $urandom);
        stop_sender();

        // largest extents: address near the top of the 48-bit range
        set_shape(12'd4, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF);
        send_fields(1'b1, 16'd4094, 16'd4094, 16'd4094, 16'd4094, 32'hFFFF_FFFF);
        send_fields(1'b0, 16'h7FFF, 16'd0, 16'd0, 16'd0, $urandom);
        send_fields(1'b1, 16'd4095, 16'd0, 16'd0, 16'd0, $urandom);
        stop_sender();

        // scalar: nothing checked, always address zero
        set_shape(12'd0, 12'd0, 12'd0, 12'd0, 12'd0);
        send_fields(1'b1, 16'h8000, 16'h7FFF, 16'hFFFF, 16'h0000, $urandom);
        send_fields(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, $urandom);
        stop_sender();

        // a used dimension of size zero rejects everything
        set_shape(12'd2, 12'd5, 12'd0, 12'd3, 12'd3);
        send_fields(1'b1, 16'd0, 16'd0, 16'd0, 16'd0, $urandom);
        send_fields(1'b1, 16'd4, 16'd0, 16'd0, 16'd0, $urandom);
        stop_sender();

        // dimension count above four clamps to four
        set_shape(12'hFFF, 12'd2, 12'd3, 12'd4, 12'd5);
        send_fields(1'b1, 16'd1, 16'd2, 16'd3, 16'd4, $urandom);
        send_fields(1'b1, 16'd1, 16'd2, 16'd3, 16'd5, $urandom);
        stop_sender();

        // writes to unmapped indexes must leave the shape alone
        wait_drained();
        for (k = CFG_SIZE3 + 1; k < (1 << CFG_IDX_W); k++) write_reg(CFG_IDX_W'(k), 12'($urandom));
        send_fields(1'b1, 16'd1, 16'd1, 16'd1, 16'd1, $urandom);
        stop_sender();

        for (ph = 0; ph < 9; ph++) begin
            if ($urandom_range(3) == 0) begin
                dims = 3'($urandom_range(7));
            end else begin
                dims = 3'($urandom_range(4, 1));
            end
            for (k = 0; k < NUM_COORDS; k++) begin
                case ($urandom_range(19))
                    0: sz[k] = 12'd0;
                    1: sz[k] = 12'hFFF;
                    2, 3: sz[k] = 12'($urandom);
                    default: sz[k] = 12'($urandom_range(12, 1));
                endcase
            end
            set_shape({9'($urandom), dims}, sz[0], sz[1], sz[2], sz[3]);
            calm <= (ph == 4);
            for (k = 0; k < 100; k++) begin
                // hold off once until the pipe is empty mid-stream
                if (ph == 2 && k == 50) begin
                    stop_sender();
                    wait_drained();
                end
                send_entry(make_entry());
            end
            stop_sender();
        end
        calm <= 1'b0;

        wait_drained();
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
